// ===== src/assert_macros.svh =====
// assertion macros for the barometer compensation rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define BARO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true out of reset
`define BARO_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/baro_pkg.sv =====
// shared types and constants for the barometer compensation block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package baro_pkg;

  // queue between temperature front end and pressure back end
  localparam int QUEUE_DEPTH = 4;

  // fine temperature width
  localparam int TF_W = 24;
  // divider: quotient bits, divisor magnitude, dividend magnitude, partial remainder
  localparam int QW = 38;
  localparam int DW = 46;
  localparam int NW = 83;
  localparam int PW = DW + 1;

  // saturation limits of the pressure quotient (signed 38 bit)
  localparam logic [QW-1:0] QSAT_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] QSAT_MIN = {1'b1, {(QW-1){1'b0}}};

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_TEMP  = 2'd0,
    REG_PLOW  = 2'd1,
    REG_PHIGH = 2'd2,
    REG_P9    = 2'd3
  } cfg_idx_t;

  // calibration coefficients, t1 and p1 unsigned, the rest two's complement
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } coef_t;

  // queue entry: front end result plus raw pressure
  typedef struct packed {
    logic [TF_W-1:0] tfine;
    logic [15:0]     temp;
    logic [19:0]     rp;
  } qent_t;

  // sideband carried along the divider
  typedef struct packed {
    logic [15:0] temp;
    logic        dz;
    logic        neg;
  } dside_t;

endpackage

`default_nettype wire

// ===== src/baro_front.sv =====
// front end: accepts raw words, computes fine temperature and saturated temperature
// depends on baro_pkg
`timescale 1ns / 1ps
`default_nettype none

module baro_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [19:0]       in_raw_temperature,
  input  logic [19:0]       in_raw_pressure,
  input  baro_pkg::coef_t   coef,
  input  logic              q_full,
  output logic              q_push,
  output baro_pkg::qent_t   q_data
);

  logic fe;
  logic v1_r, v2_r, v3_r;
  logic [19:0] rp1_r, rp2_r;
  logic signed [33:0] m1_r, dd_r;
  logic signed [22:0] tv1_r;
  logic signed [37:0] m2_r;
  baro_pkg::qent_t ent_r;

  logic signed [17:0] a1;
  logic signed [16:0] dt;
  logic signed [33:0] m1, dd;
  logic signed [21:0] ddh;
  logic signed [37:0] m2;
  logic signed [baro_pkg::TF_W-1:0] tfine;
  logic signed [26:0] t5;
  logic signed [18:0] tt;
  logic signed [15:0] tsat;

  // pipeline advances unless the last stage is blocked by a full queue
  assign fe       = !v3_r || !q_full;
  assign in_ready = fe;
  assign q_push   = v3_r && !q_full;
  assign q_data   = ent_r;

  // stage 1 products
  assign a1 = $signed({1'b0, in_raw_temperature[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
  assign m1 = a1 * $signed(coef.t2);
  assign dt = $signed({1'b0, in_raw_temperature[19:4]}) - $signed({1'b0, coef.t1});
  assign dd = dt * dt;

  // stage 2 second order term
  assign ddh = $signed(dd_r[33:12]);
  assign m2  = ddh * $signed(coef.t3);

  // stage 3 fine temperature and centi-degree result
  assign tfine = $signed({tv1_r[22], tv1_r}) + $signed(m2_r[37:14]);
  assign t5 = ($signed({{3{tfine[23]}}, tfine}) <<< 2) + $signed({{3{tfine[23]}}, tfine})
              + 27'sd128;
  assign tt = $signed(t5[26:8]);

  always_comb begin
    if (tt > 19'sd32767) begin
      tsat = 16'sh7fff;
    end else if (tt < -19'sd32768) begin
      tsat = 16'sh8000;
    end else begin
      tsat = $signed(tt[15:0]);
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (fe) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (fe) begin
      rp1_r       <= in_raw_pressure;
      m1_r        <= m1;
      dd_r        <= dd;
      rp2_r       <= rp1_r;
      tv1_r       <= m1_r[33:11];
      m2_r        <= m2;
      ent_r.tfine <= tfine;
      ent_r.temp  <= tsat;
      ent_r.rp    <= rp2_r;
    end
  end

endmodule

`default_nettype wire

// ===== src/baro_queue.sv =====
// short fifo between the front end and the pressure back end
// depends on baro_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module baro_queue #(
  parameter int DEPTH = baro_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  baro_pkg::qent_t din,
  output logic            full,
  input  logic            pop,
  output baro_pkg::qent_t dout,
  output logic            empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  baro_pkg::qent_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `BARO_NEVER(a_push_full, push && full, "word pushed into full queue")
  `BARO_NEVER(a_pop_empty, pop && empty, "word popped from empty queue")
  `BARO_ASSERT(a_count_up, (push && !pop) |=> (count_r == $past(count_r) + 1'b1), "count lost")

endmodule

`default_nettype wire

// ===== src/baro_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow detect
// depends on baro_pkg
`timescale 1ns / 1ps
`default_nettype none

module baro_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [baro_pkg::NW-1:0]      num,
  input  logic [baro_pkg::DW-1:0]      den,
  input  baro_pkg::dside_t             side_in,
  output logic                         out_vld,
  output logic [baro_pkg::QW-1:0]      quo,
  output logic                         ovf,
  output baro_pkg::dside_t             side_out
);

  localparam int QW = baro_pkg::QW;
  localparam int DW = baro_pkg::DW;
  localparam int NW = baro_pkg::NW;
  localparam int PW = baro_pkg::PW;

  logic [QW:0] vld_r;
  logic [QW:0] ovf_r;
  logic [PW-1:0] rem_r [QW+1];
  logic [QW-1:0] lo_r [QW+1];
  logic [QW-1:0] q_r [QW+1];
  logic [DW-1:0] d_r [QW+1];
  baro_pkg::dside_t sb_r [QW+1];

  assign out_vld  = vld_r[QW];
  assign quo      = q_r[QW];
  assign ovf      = ovf_r[QW];
  assign side_out = sb_r[QW];

  // valid shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-1:0], in_vld};
    end
  end

  // entry stage: top dividend bits as the first partial remainder
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= PW'(num[NW-1:QW]);
      lo_r[0]  <= num[QW-1:0];
      q_r[0]   <= '0;
      d_r[0]   <= den;
      sb_r[0]  <= side_in;
      ovf_r[0] <= (DW'(num[NW-1:QW]) >= den);
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [PW-1:0] trial;
    logic          ge;

    assign trial = {rem_r[k-1][PW-2:0], lo_r[k-1][QW-1]};
    assign ge    = (trial >= PW'(d_r[k-1]));

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? trial - PW'(d_r[k-1]) : trial;
        lo_r[k]  <= {lo_r[k-1][QW-2:0], 1'b0};
        q_r[k]   <= {q_r[k-1][QW-2:0], ge};
        d_r[k]   <= d_r[k-1];
        sb_r[k]  <= sb_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/baro_back.sv =====
// back end: pressure polynomial, divisor, division and second order correction
// depends on baro_pkg and baro_div
`timescale 1ns / 1ps
`default_nettype none

module baro_back (
  input  logic             clk,
  input  logic             rst_n,
  input  baro_pkg::coef_t  coef,
  input  logic             q_empty,
  output logic             q_pop,
  input  baro_pkg::qent_t  q_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic signed [15:0] out_temperature_centi,
  output logic [31:0]      out_pressure_q24_8,
  output logic             out_pressure_valid
);

  localparam int QW = baro_pkg::QW;
  localparam int DW = baro_pkg::DW;
  localparam int NW = baro_pkg::NW;

  logic be;

  // stage valids
  logic b1_r, b2_r, b3_r, b4_r, b5_r, b6_r, b8_r, b9_r, b10_r, ov_r;
  logic dv;

  // stage payloads
  logic [15:0] t1_r, t2_r, t3_r, t4_r, t5_r, t6_r, t8_r, t9_r, t10_r;
  logic [19:0] rp1_r, rp2_r, rp3_r;
  logic signed [51:0] ww_r;
  logic signed [41:0] wp5_r, wp2_r, wp5b_r, wp2b_r;
  logic signed [67:0] a6_r, a3_r, v2_r;
  logic signed [61:0] aa_r;
  logic signed [45:0] dq_r;
  logic signed [69:0] num_r;
  logic signed [82:0] nm_r;
  logic [DW-1:0] ad_r, ad6_r;
  logic dz5_r, dz6_r, sd5_r, neg6_r, dz8_r, dz9_r, dz10_r;
  logic [NW-1:0] an_r;
  logic signed [QW-1:0] p_r, p9_r, p10_r;
  logic signed [49:0] xx_r;
  logic signed [53:0] p8p_r, p8p10_r;
  logic signed [65:0] m9_r;

  // combinational terms
  logic signed [25:0] w;
  logic signed [51:0] ww;
  logic signed [41:0] wp5, wp2;
  logic signed [67:0] a6, a3, v2;
  logic signed [61:0] aa;
  logic signed [78:0] prod;
  logic [20:0] s;
  logic signed [69:0] num;
  logic signed [82:0] nm;
  logic [DW-1:0] ad;
  logic [NW-1:0] an;
  logic [QW-1:0] dquo;
  logic dovf;
  baro_pkg::dside_t dside_in, dside_out;
  logic [QW-1:0] psat;
  logic signed [24:0] x;
  logic signed [49:0] xx;
  logic signed [53:0] p8p;
  logic signed [65:0] m9;
  logic signed [42:0] sum;
  logic signed [35:0] fin;
  logic [31:0] pclamp;

  // whole back end moves when the output register is free or being taken
  assign be        = !ov_r || out_ready;
  assign q_pop     = be && !q_empty;
  assign out_valid = ov_r;

  // stage 1: temperature offset and its products
  assign w   = $signed({{2{q_data.tfine[23]}}, q_data.tfine}) - 26'sd128000;
  assign ww  = w * w;
  assign wp5 = w * $signed(coef.p5);
  assign wp2 = w * $signed(coef.p2);

  // stage 2: square term times p6 and p3
  assign a6 = ww_r * $signed(coef.p6);
  assign a3 = ww_r * $signed(coef.p3);

  // stage 3: numerator offset and divisor base
  assign v2 = a6_r + $signed({{9{wp5b_r[41]}}, wp5b_r, 17'b0})
              + $signed({{17{coef.p4[15]}}, coef.p4, 35'b0});
  assign aa = $signed({{2{a3_r[67]}}, a3_r[67:8]})
              + $signed({{8{wp2b_r[41]}}, wp2b_r, 12'b0})
              + 62'sd140737488355328;

  // stage 4: divisor and numerator
  assign prod = aa_r * $signed({1'b0, coef.p1});
  assign s    = 21'd1048576 - {1'b0, rp3_r};
  assign num  = $signed({18'b0, s, 31'b0}) - $signed({{2{v2_r[67]}}, v2_r});

  // stage 5: scale numerator, divisor magnitude
  assign nm = num_r * 13'sd3125;
  assign ad = dq_r[45] ? DW'(-dq_r) : DW'(dq_r);

  // stage 6: numerator magnitude
  assign an = nm_r[82] ? NW'(-nm_r) : NW'(nm_r);

  assign dside_in.temp = t6_r;
  assign dside_in.dz   = dz6_r;
  assign dside_in.neg  = neg6_r;

  baro_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (be),
    .in_vld   (b6_r),
    .num      (an_r),
    .den      (ad6_r),
    .side_in  (dside_in),
    .out_vld  (dv),
    .quo      (dquo),
    .ovf      (dovf),
    .side_out (dside_out)
  );

  // quotient sign and saturation to 38 bits
  always_comb begin
    if (dovf) begin
      psat = dside_out.neg ? baro_pkg::QSAT_MIN : baro_pkg::QSAT_MAX;
    end else if (dside_out.neg) begin
      psat = (dquo > baro_pkg::QSAT_MIN) ? baro_pkg::QSAT_MIN : QW'(-dquo);
    end else begin
      psat = (dquo > baro_pkg::QSAT_MAX) ? baro_pkg::QSAT_MAX : dquo;
    end
  end

  // second order correction terms
  assign x   = $signed(p_r[37:13]);
  assign xx  = x * x;
  assign p8p = $signed(coef.p8) * p_r;
  assign m9  = xx_r * $signed(coef.p9);

  // final sum, scale and clamp to unsigned 32 bits
  assign sum = $signed({{5{p10_r[37]}}, p10_r}) + $signed({{2{m9_r[65]}}, m9_r[65:25]})
               + $signed({{8{p8p10_r[53]}}, p8p10_r[53:19]});
  assign fin = $signed({sum[42], sum[42:8]}) + $signed({{16{coef.p7[15]}}, coef.p7, 4'b0});

  always_comb begin
    if (fin < 36'sd0) begin
      pclamp = 32'd0;
    end else if (fin > 36'sd4294967295) begin
      pclamp = 32'hffff_ffff;
    end else begin
      pclamp = fin[31:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_r  <= 1'b0;
      b2_r  <= 1'b0;
      b3_r  <= 1'b0;
      b4_r  <= 1'b0;
      b5_r  <= 1'b0;
      b6_r  <= 1'b0;
      b8_r  <= 1'b0;
      b9_r  <= 1'b0;
      b10_r <= 1'b0;
      ov_r  <= 1'b0;
    end else if (be) begin
      b1_r  <= !q_empty;
      b2_r  <= b1_r;
      b3_r  <= b2_r;
      b4_r  <= b3_r;
      b5_r  <= b4_r;
      b6_r  <= b5_r;
      b8_r  <= dv;
      b9_r  <= b8_r;
      b10_r <= b9_r;
      ov_r  <= b10_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (be) begin
      t1_r   <= q_data.temp;
      rp1_r  <= q_data.rp;
      ww_r   <= ww;
      wp5_r  <= wp5;
      wp2_r  <= wp2;

      t2_r   <= t1_r;
      rp2_r  <= rp1_r;
      a6_r   <= a6;
      a3_r   <= a3;
      wp5b_r <= wp5_r;
      wp2b_r <= wp2_r;

      t3_r   <= t2_r;
      rp3_r  <= rp2_r;
      v2_r   <= v2;
      aa_r   <= aa;

      t4_r   <= t3_r;
      dq_r   <= prod[78:33];
      num_r  <= num;

      t5_r   <= t4_r;
      nm_r   <= nm;
      ad_r   <= ad;
      dz5_r  <= (dq_r == '0);
      sd5_r  <= dq_r[45];

      t6_r   <= t5_r;
      an_r   <= an;
      ad6_r  <= ad_r;
      dz6_r  <= dz5_r;
      neg6_r <= nm_r[82] ^ sd5_r;

      t8_r   <= dside_out.temp;
      dz8_r  <= dside_out.dz;
      p_r    <= psat;

      t9_r   <= t8_r;
      dz9_r  <= dz8_r;
      p9_r   <= p_r;
      xx_r   <= xx;
      p8p_r  <= p8p;

      t10_r   <= t9_r;
      dz10_r  <= dz9_r;
      p10_r   <= p9_r;
      m9_r    <= m9;
      p8p10_r <= p8p_r;

      out_temperature_centi <= $signed(t10_r);
      out_pressure_q24_8    <= dz10_r ? 32'd0 : pclamp;
      out_pressure_valid    <= !dz10_r;
    end
  end

endmodule

`default_nettype wire

// ===== src/barometer_compensation.sv =====
// barometer compensation top level: configuration registers, front end, queue, back end
// depends on baro_pkg, baro_front, baro_queue, baro_back
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_we                cfg_index, cfg_data
//   in       in         in_valid / in_ready   in_raw_temperature, in_raw_pressure
//   out      out        out_valid / out_ready temperature, pressure, pressure valid
//
// one word per cycle sustained while results are taken at the output; the divider pipeline
// is an entry register plus 38 quotient stages
// reset is synchronous, active low, and clears valids, queue and coefficients
// a stalled output freezes the back end; the queue lets the front end keep taking words
// configuration is to be written only while no word is in flight; the block does not enforce it
`timescale 1ns / 1ps
`default_nettype none

module barometer_compensation #(
  parameter int QUEUE_DEPTH = baro_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [19:0]        in_raw_temperature,
  input  logic [19:0]        in_raw_pressure,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_temperature_centi,
  output logic [31:0]        out_pressure_q24_8,
  output logic               out_pressure_valid
);

  logic [47:0] temp_coef_r;
  logic [63:0] plow_r, phigh_r;
  logic [15:0] p9_r;
  baro_pkg::coef_t coef;
  baro_pkg::qent_t q_din, q_dout;
  logic q_push, q_full, q_pop, q_empty;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coef_r <= '0;
      plow_r      <= '0;
      phigh_r     <= '0;
      p9_r        <= '0;
    end else if (cfg_we) begin
      unique case (baro_pkg::cfg_idx_t'(cfg_index))
        baro_pkg::REG_TEMP:  temp_coef_r <= cfg_data[47:0];
        baro_pkg::REG_PLOW:  plow_r      <= cfg_data;
        baro_pkg::REG_PHIGH: phigh_r     <= cfg_data;
        baro_pkg::REG_P9:    p9_r        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // unpack
  assign coef.t1 = temp_coef_r[15:0];
  assign coef.t2 = temp_coef_r[31:16];
  assign coef.t3 = temp_coef_r[47:32];
  assign coef.p1 = plow_r[15:0];
  assign coef.p2 = plow_r[31:16];
  assign coef.p3 = plow_r[47:32];
  assign coef.p4 = plow_r[63:48];
  assign coef.p5 = phigh_r[15:0];
  assign coef.p6 = phigh_r[31:16];
  assign coef.p7 = phigh_r[47:32];
  assign coef.p8 = phigh_r[63:48];
  assign coef.p9 = p9_r;

  baro_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_raw_temperature (in_raw_temperature),
    .in_raw_pressure    (in_raw_pressure),
    .coef               (coef),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_data             (q_din)
  );

  baro_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  baro_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .coef                  (coef),
    .q_empty               (q_empty),
    .q_pop                 (q_pop),
    .q_data                (q_dout),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure_q24_8    (out_pressure_q24_8),
    .out_pressure_valid    (out_pressure_valid)
  );

endmodule

`default_nettype wire
